// File: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tcw_pkg
// Shared types and constants for the text console writer.
// ============================================================================
package tcw_pkg;

    // Fixed field widths
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int ADDR_W  = 11;
    localparam int LIN_W   = 12;    // linear cell index, covers up to 128 x 32 cells
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    // Tab stops every 4 columns
    localparam logic [COL_W:0]    TAB_STEP = 8'd4;
    localparam logic [COL_W:0]    TAB_MASK = ~8'd3;

    localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h07;
    localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_COLOR, CHAR_SPACE};

    // Register map: word index taken from paddr[2]
    localparam logic REG_TEXT_COLOR = 1'b0;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Screen memory control from the top level
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic sweep_start;
        logic sweep_copy;
    } tcw_ram_ctl_t;

    // Screen memory status
    typedef struct packed {
        logic busy;
        logic done;
    } tcw_ram_sts_t;

    // Cursor update for the word being accepted
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             scroll;
        logic             wr_en;
    } tcw_cur_t;

endpackage

// File: rtl/core/tcw_cursor.sv
`timescale 1ns / 1ps
// ============================================================================
// tcw_cursor
// Cursor row/column registers and the put-character position update.
// ============================================================================
module tcw_cursor #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  tcw_pkg::op_t                 operation,
    input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
    output tcw_pkg::tcw_cur_t            nxt,
    output logic [tcw_pkg::LIN_W-1:0]    lin_addr
);
    import tcw_pkg::*;

    localparam logic [COL_W:0]   WIDTH_LIM  = (COL_W+1)'(SCREEN_WIDTH);
    localparam logic [ROW_W:0]   HEIGHT_LIM = (ROW_W+1)'(SCREEN_HEIGHT);
    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(SCREEN_HEIGHT - 1);

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W:0]   col_inc;
    logic [COL_W:0]   col_tab;
    logic [ROW_W:0]   row_inc;
    logic             wrap;
    logic             scroll;
    logic             wr_en;

    always_comb
    begin
        col_inc  = {1'b0, col_reg} + (COL_W+1)'(1);
        col_tab  = ({1'b0, col_reg} + TAB_STEP) & TAB_MASK;
        row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);
        row_next = row_reg;
        col_next = col_reg;
        wrap     = 1'b0;
        wr_en    = 1'b0;
        scroll   = 1'b0;
        case (operation)
            OP_PUT:
            begin
                case (char_code)
                    CHAR_NEWLINE: wrap = 1'b1;
                    CHAR_RETURN:  col_next = '0;
                    CHAR_TAB:
                    begin
                        if (col_tab >= WIDTH_LIM)
                            wrap = 1'b1;
                        else
                            col_next = col_tab[COL_W-1:0];
                    end
                    default:
                    begin
                        wr_en = 1'b1;
                        if (col_inc >= WIDTH_LIM)
                            wrap = 1'b1;
                        else
                            col_next = col_inc[COL_W-1:0];
                    end
                endcase
            end
            OP_CLEAR:
            begin
                row_next = '0;
                col_next = '0;
            end
            default: ;
        endcase
        // next line; past the last row the screen scrolls
        if (wrap)
        begin
            col_next = '0;
            if (row_inc >= HEIGHT_LIM)
            begin
                row_next = LAST_ROW;
                scroll   = 1'b1;
            end
            else
            begin
                row_next = row_inc[ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (step)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // cell under the cursor, before the update
    assign lin_addr = LIN_W'(row_reg) * LIN_W'(SCREEN_WIDTH) + LIN_W'(col_reg);

    assign nxt.row    = row_next;
    assign nxt.col    = col_next;
    assign nxt.scroll = scroll;
    assign nxt.wr_en  = wr_en;

endmodule

// File: rtl/core/tcw_screen.sv
`timescale 1ns / 1ps
// ============================================================================
// tcw_screen
// Screen cell memory with a sweep engine for scroll, clear and reset fill.
// ============================================================================
module tcw_screen #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25,
    parameter int AW            = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tcw_pkg::tcw_ram_ctl_t        ctl,
    input  logic [AW-1:0]                wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0]   wr_data,
    input  logic [AW-1:0]                rd_addr,
    input  logic [tcw_pkg::CELL_W-1:0]   sweep_blank,
    output logic [tcw_pkg::CELL_W-1:0]   rd_data,
    output tcw_pkg::tcw_ram_sts_t        sts
);
    import tcw_pkg::*;

    localparam int            CELLS      = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int            AW1        = AW + 1;
    localparam logic [AW:0]   COPY_LIMIT = AW1'(CELLS - SCREEN_WIDTH);
    localparam logic [AW-1:0] LAST_IDX   = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_OFF    = AW'(SCREEN_WIDTH);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    logic              sw_active_reg, sw_active_next;
    logic [AW-1:0]     sw_idx_reg, sw_idx_next;
    logic              sw_copy_reg, sw_copy_next;
    logic [CELL_W-1:0] sw_blank_reg, sw_blank_next;
    logic              wp_valid_reg;
    logic [AW-1:0]     wp_addr_reg;
    logic              wp_copy_reg;

    logic              sw_in_copy;
    logic [AW-1:0]     sw_src;
    logic              ram_rd;
    logic [AW-1:0]     ram_raddr;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;

    // sweep reads one row ahead, writes the cell in the next cycle
    always_comb
    begin
        sw_in_copy = sw_copy_reg && ({1'b0, sw_idx_reg} < COPY_LIMIT);
        sw_src     = sw_idx_reg + ROW_OFF;
        ram_rd     = (sw_active_reg && sw_in_copy) || ctl.rd_en;
        ram_raddr  = sw_active_reg ? sw_src : rd_addr;
        ram_we     = wp_valid_reg || ctl.wr_en;
        ram_waddr  = wp_valid_reg ? wp_addr_reg : wr_addr;
        if (wp_valid_reg)
            ram_wdata = wp_copy_reg ? rd_data_reg : sw_blank_reg;
        else
            ram_wdata = wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
            mem[ram_waddr] <= ram_wdata;
        if (ram_rd)
            rd_data_reg <= mem[ram_raddr];
    end

    always_comb
    begin
        sw_active_next = sw_active_reg;
        sw_idx_next    = sw_idx_reg;
        sw_copy_next   = sw_copy_reg;
        sw_blank_next  = sw_blank_reg;
        if (ctl.sweep_start)
        begin
            sw_active_next = 1'b1;
            sw_idx_next    = '0;
            sw_copy_next   = ctl.sweep_copy;
            sw_blank_next  = sweep_blank;
        end
        else if (sw_active_reg)
        begin
            sw_idx_next = sw_idx_reg + AW'(1);
            if (sw_idx_reg == LAST_IDX)
                sw_active_next = 1'b0;
        end
    end

    // reset starts a blanking sweep with the reset colour
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_active_reg <= 1'b1;
            sw_idx_reg    <= '0;
            sw_copy_reg   <= 1'b0;
            sw_blank_reg  <= RESET_BLANK;
            wp_valid_reg  <= 1'b0;
        end
        else
        begin
            sw_active_reg <= sw_active_next;
            sw_idx_reg    <= sw_idx_next;
            sw_copy_reg   <= sw_copy_next;
            sw_blank_reg  <= sw_blank_next;
            wp_valid_reg  <= sw_active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wp_addr_reg <= sw_idx_reg;
        wp_copy_reg <= sw_in_copy;
    end

    assign rd_data  = rd_data_reg;
    assign sts.busy = sw_active_reg || wp_valid_reg;
    assign sts.done = wp_valid_reg && !sw_active_reg;

endmodule

// File: rtl/core/text_console_writer.sv
`timescale 1ns / 1ps
// ============================================================================
// text_console_writer
// Text-mode console: screen of character cells, cursor, scroll and clear.
// ============================================================================
// Each input word is one operation and returns one output word with the
// cursor position after it. Puts of a character, newline, return or tab
// that do not scroll stream at one word per clock while the output side
// keeps up; a read waits in S_READ for the registered read data of the
// screen memory. Scroll and clear walk the whole screen through the read
// and write ports of the screen memory, one cell per cycle, with in_ready
// low meanwhile. After reset the screen is filled with blank grey cells
// (0x0720) in the same way before the first word is taken; APB writes are
// accepted throughout.
// A finished result sits in a holding register behind the output register,
// so one word may be processed while the previous one waits to be taken.
// text_color (APB address 0) sets the attribute byte of written cells and of
// the blanks used by clear and scroll. Reads past the last cell return 0.
// ============================================================================
module text_console_writer #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input words
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    operation,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::ADDR_W-1:0]    cell_address,
    // output words
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tcw_pkg::CELL_W-1:0]    cell_value,
    output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
    output logic [tcw_pkg::COL_W-1:0]     cursor_column,
    output logic                          scrolled,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import tcw_pkg::*;

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam logic [LIN_W:0] CELL_LIMIT = (LIN_W+1)'(CELLS);

    typedef enum logic [3:0] {
        S_INIT  = 4'b0001,   // reset blanking sweep
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,   // waiting on memory read data
        S_SWEEP = 4'b1000    // scroll or clear in progress
    } state_t;

    state_t            state_reg, state_next;

    logic [CHAR_W-1:0] text_color_reg;
    logic              apb_wr;

    op_t               op_in;
    logic              accept;
    logic              pend_move;
    tcw_cur_t          cur;
    logic [LIN_W-1:0]  cur_lin;
    tcw_ram_ctl_t      ram_ctl;
    tcw_ram_sts_t      ram_sts;
    logic [CELL_W-1:0] ram_rd_data;
    logic              rd_ok_reg;

    // holding stage
    logic              pend_valid_reg, pend_valid_next;
    logic [CELL_W-1:0] pend_cell_reg;
    logic [ROW_W-1:0]  pend_row_reg;
    logic [COL_W-1:0]  pend_col_reg;
    logic              pend_scr_reg;

    // output stage
    logic              out_valid_reg;
    logic [CELL_W-1:0] out_cell_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic              out_scr_reg;

    // ------------------------------------------------------------------
    // APB register
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_TEXT_COLOR) ? PDATA_W'(text_color_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text_color_reg <= RESET_COLOR;
        else if (apb_wr && (paddr[2] == REG_TEXT_COLOR))
            text_color_reg <= pwdata[CHAR_W-1:0];
    end

    // ------------------------------------------------------------------
    // Input handshake
    // ------------------------------------------------------------------
    assign op_in     = op_t'(operation);
    assign pend_move = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE) && !ram_sts.busy
                       && (!pend_valid_reg || pend_move);
    assign accept    = in_valid && in_ready;

    tcw_cursor #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .operation (op_in),
        .char_code (char_code),
        .nxt       (cur),
        .lin_addr  (cur_lin)
    );

    // Memory requests: cell write on put, read on read, sweep on
    // scroll (copy rows up, blank last row) or clear (blank all).
    always_comb
    begin
        ram_ctl.wr_en       = accept && (op_in == OP_PUT) && cur.wr_en;
        ram_ctl.rd_en       = accept && (op_in == OP_READ);
        ram_ctl.sweep_start = accept && (((op_in == OP_PUT) && cur.scroll)
                                         || (op_in == OP_CLEAR));
        ram_ctl.sweep_copy  = (op_in == OP_PUT);
    end

    tcw_screen #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .AW            (AW)
    ) u_screen (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ram_ctl),
        .wr_addr     (cur_lin[AW-1:0]),
        .wr_data     ({text_color_reg, char_code}),
        .rd_addr     (AW'(cell_address)),
        .sweep_blank ({text_color_reg, CHAR_SPACE}),
        .rd_data     (ram_rd_data),
        .sts         (ram_sts)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (ram_sts.done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (ram_ctl.rd_en)
                    state_next = S_READ;
                else if (ram_ctl.sweep_start)
                    state_next = S_SWEEP;
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            S_SWEEP:
            begin
                if (ram_sts.done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result is complete at accept unless it waits for read data or a sweep.
    always_comb
    begin
        pend_valid_next = pend_valid_reg && !pend_move;
        if (accept)
            pend_valid_next = !ram_ctl.rd_en && !ram_ctl.sweep_start;
        else if (state_reg == S_READ)
            pend_valid_next = 1'b1;
        else if ((state_reg == S_SWEEP) && ram_sts.done)
            pend_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            if (pend_move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_cell_reg <= '0;
            pend_row_reg  <= cur.row;
            pend_col_reg  <= cur.col;
            pend_scr_reg  <= cur.scroll;
            rd_ok_reg     <= ((LIN_W+1)'(cell_address) < CELL_LIMIT);
        end
        else if (state_reg == S_READ)
        begin
            pend_cell_reg <= rd_ok_reg ? ram_rd_data : '0;
        end

        if (pend_move)
        begin
            out_cell_reg <= pend_cell_reg;
            out_row_reg  <= pend_row_reg;
            out_col_reg  <= pend_col_reg;
            out_scr_reg  <= pend_scr_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cell_value    = out_cell_reg;
    assign cursor_row    = out_row_reg;
    assign cursor_column = out_col_reg;
    assign scrolled      = out_scr_reg;

endmodule

// File: rtl/core/tcw_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
// ============================================================================
module tcw_checker #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] cell_value,
    input logic [4:0]  cursor_row,
    input logic [6:0]  cursor_column,
    input logic        scrolled
);
    localparam logic [5:0] HEIGHT_LIM = 6'(SCREEN_HEIGHT);
    localparam logic [7:0] WIDTH_LIM  = 8'(SCREEN_WIDTH);
    localparam logic [4:0] LAST_ROW   = 5'(SCREEN_HEIGHT - 1);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_value)
            && $stable(cursor_row) && $stable(cursor_column) && $stable(scrolled))
        else $error("output word changed while stalled");

    // cursor always on screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, cursor_row} < HEIGHT_LIM)
            && ({1'b0, cursor_column} < WIDTH_LIM))
        else $error("cursor off screen");

    // a scroll leaves the cursor at the start of the last row
    a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> (cursor_row == LAST_ROW) && (cursor_column == 7'd0))
        else $error("scroll with cursor not at last row start");

    // only reads carry cell data, and reads never scroll
    a_scroll_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> (cell_value == 16'd0))
        else $error("scrolling word carries cell data");

endmodule

bind text_console_writer tcw_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cell_value    (cell_value),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column),
    .scrolled      (scrolled)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the text console writer.
// ============================================================================
// Input words go in over a valid/ready channel and every accepted word is run
// through a shadow console (screen, cursor, text colour) kept here. The shadow
// result is queued, and each output word is compared field by field with the
// oldest queued entry. The run has three parts:
//   - a directed table of reads, puts and clears around the screen edges;
//   - random segments of well-formed traffic: text lines, newline bursts,
//     reads and the odd clear, plus some raw noise words;
//   - text_color rewritten and read back over APB between segments, only
//     once the console has gone idle.
// Backpressure changes per group of segments: receiver-heavy stalls, then
// sender-heavy gaps, then none at all.
// ============================================================================
module tb_top;

    import tcw_pkg::*;

    localparam int SCR_W         = 80;
    localparam int SCR_H         = 25;
    localparam int CELLS         = SCR_W * SCR_H;
    localparam int TAB_STOP      = 4;
    localparam int SEGMENTS      = 9;
    localparam int SEG_WORDS     = 160;
    localparam int STALL_LIMIT   = 10000;  // > one full-screen sweep plus stalls
    localparam int SETTLE_CYCLES = 50;
    localparam int FAULT_SHOWN   = 10;
    localparam int DIRECTED_ROWS = 22;

    localparam logic [PADDR_W-1:0] COLOR_ADDR = {REG_TEXT_COLOR, 2'b00};

    // One output word as seen on the result port
    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              scrolled;
    } console_word_t;

    // Directed table row; want is only used when typed is set
    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        console_word_t     want;
    } stim_row_t;

    localparam console_word_t NO_WORD = '0;

    // ------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic [1:0]          operation    = '0;
    logic [CHAR_W-1:0]   char_code    = '0;
    logic [ADDR_W-1:0]   cell_address = '0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic [CELL_W-1:0]   cell_value;
    logic [ROW_W-1:0]    cursor_row;
    logic [COL_W-1:0]    cursor_column;
    logic                scrolled;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    text_console_writer #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .char_code     (char_code),
        .cell_address  (cell_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_value    (cell_value),
        .cursor_row    (cursor_row),
        .cursor_column (cursor_column),
        .scrolled      (scrolled),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow console
    // ------------------------------------------------------------------
    logic [CELL_W-1:0] shadow_screen [CELLS];
    int unsigned       shadow_row;
    int unsigned       shadow_col;
    logic [CHAR_W-1:0] shadow_color;

    console_word_t     pending_words [$];   // expected output words, oldest first
    int                fault_count   = 0;
    int                words_sent    = 0;
    int                words_checked = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                stall_cycles  = 0;

    function automatic void blank_shadow();
        for (int i = 0; i < CELLS; i++)
            shadow_screen[i] = {shadow_color, CHAR_SPACE};
        shadow_row = 0;
        shadow_col = 0;
    endfunction

    // Column 0 of the next row; past the bottom the screen moves up one line
    // and the new bottom line is blanked in the current colour.
    function automatic logic line_feed_shadow();
        shadow_col = 0;
        shadow_row++;
        if (shadow_row < SCR_H)
            return 1'b0;
        shadow_row = SCR_H - 1;
        for (int i = 0; i + SCR_W < CELLS; i++)
            shadow_screen[i] = shadow_screen[i + SCR_W];
        for (int i = CELLS - SCR_W; i < CELLS; i++)
            shadow_screen[i] = {shadow_color, CHAR_SPACE};
        return 1'b1;
    endfunction

    function automatic console_word_t advance_console(op_t op, logic [CHAR_W-1:0] ch,
                                                      logic [ADDR_W-1:0] addr);
        console_word_t w;
        int unsigned   idx;
        w = NO_WORD;
        case (op)
            OP_PUT: begin
                if (ch == CHAR_NEWLINE) begin
                    w.scrolled = line_feed_shadow();
                end else if (ch == CHAR_RETURN) begin
                    shadow_col = 0;
                end else if (ch == CHAR_TAB) begin
                    shadow_col = shadow_col + TAB_STOP - (shadow_col % TAB_STOP);
                    if (shadow_col >= SCR_W)
                        w.scrolled = line_feed_shadow();
                end else begin
                    idx = shadow_row * SCR_W + shadow_col;
                    if (idx < CELLS)
                        shadow_screen[idx] = {shadow_color, ch};
                    shadow_col++;
                    if (shadow_col >= SCR_W)
                        w.scrolled = line_feed_shadow();
                end
            end
            OP_CLEAR: blank_shadow();
            OP_READ: begin
                if (addr < CELLS)
                    w.cell_value = shadow_screen[addr];
            end
            default: ;  // unused code: nothing moves
        endcase
        w.row = ROW_W'(shadow_row);
        w.col = COL_W'(shadow_col);
        return w;
    endfunction

    function automatic void note_fault(string what);
        fault_count++;
        if (fault_count <= FAULT_SHOWN)
            $display("%t %s", $realtime, what);
    endfunction

    // ------------------------------------------------------------------
    // Word and register traffic, all driven on the rising edge
    // ------------------------------------------------------------------
    task automatic push_word(op_t op, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] addr,
                             logic typed, console_word_t want);
        console_word_t calc;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        char_code    <= ch;
        cell_address <= addr;
        do @(posedge clk); while (!in_ready);
        // shadow always runs so its state tracks typed rows too
        calc = advance_console(op, ch, addr);
        pending_words.push_back(typed ? want : calc);
        words_sent++;
    endtask

    // Drop valid, then wait for every word back and the input side open again
    // (a scroll or clear sweep keeps in_ready low).
    task automatic wait_console_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_words.size() != 0 || !in_ready);
    endtask

    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_check(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            note_fault($sformatf("text_color readback: expected %h, got %h", want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, compare against the oldest expectation
    // ------------------------------------------------------------------
    console_word_t due_word;
    console_word_t got_word;

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            got_word = {cell_value, cursor_row, cursor_column, scrolled};
            if (pending_words.size() == 0) begin
                note_fault($sformatf("unexpected word: cell %h row %0d col %0d scrolled %0b",
                                     got_word.cell_value, got_word.row, got_word.col,
                                     got_word.scrolled));
            end else begin
                due_word = pending_words.pop_front();
                if (got_word !== due_word)
                    note_fault($sformatf({"word %0d: expected cell %h row %0d col %0d ",
                                          "scrolled %0b, got cell %h row %0d col %0d ",
                                          "scrolled %0b"},
                                         words_checked, due_word.cell_value, due_word.row,
                                         due_word.col, due_word.scrolled,
                                         got_word.cell_value, got_word.row, got_word.col,
                                         got_word.scrolled));
            end
            words_checked++;
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any word moving on either side resets the count
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    stim_row_t directed_rows [DIRECTED_ROWS];

    initial begin : stimulus
        int unsigned       pick;
        int unsigned       run_len;
        int                target;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] color;

        // Reset colour, blank screen, cursor home. Typed rows are plain
        // edge values; the rest go through the shadow console.
        directed_rows = '{
            '{OP_READ,  8'h00,        11'd0,    1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
            '{OP_READ,  8'h00,        11'd1999, 1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
            // first and last address past the screen
            '{OP_READ,  8'hFF,        11'd2000, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
            '{OP_READ,  8'h00,        11'h7FF,  1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
            // unused code with every field bit set
            '{OP_NONE,  8'hFF,        11'h7FF,  1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
            // smallest and largest character, address ignored by put
            '{OP_PUT,   8'h00,        11'h7FF,  1'b1, '{16'h0000, 5'd0, 7'd1, 1'b0}},
            '{OP_PUT,   8'hFF,        11'd0,    1'b1, '{16'h0000, 5'd0, 7'd2, 1'b0}},
            '{OP_READ,  8'hFF,        11'd0,    1'b1, '{16'h0700, 5'd0, 7'd2, 1'b0}},
            '{OP_READ,  8'h00,        11'd1,    1'b1, '{16'h07FF, 5'd0, 7'd2, 1'b0}},
            '{OP_PUT,   CHAR_TAB,     11'd0,    1'b1, '{16'h0000, 5'd0, 7'd4, 1'b0}},
            '{OP_PUT,   8'h41,        11'd0,    1'b0, NO_WORD},
            '{OP_PUT,   CHAR_TAB,     11'd0,    1'b0, NO_WORD},
            '{OP_PUT,   CHAR_RETURN,  11'd0,    1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
            '{OP_PUT,   CHAR_NEWLINE, 11'd0,    1'b1, '{16'h0000, 5'd1, 7'd0, 1'b0}},
            '{OP_PUT,   8'h42,        11'd0,    1'b0, NO_WORD},
            '{OP_READ,  8'h00,        11'd80,   1'b0, NO_WORD},
            '{OP_READ,  8'hAA,        11'h555,  1'b0, NO_WORD},
            '{OP_NONE,  8'h00,        11'd0,    1'b0, NO_WORD},
            // clear ignores both data fields
            '{OP_CLEAR, 8'hFF,        11'h7FF,  1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
            '{OP_READ,  8'h00,        11'd0,    1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
            '{OP_READ,  8'h00,        11'd80,   1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
            '{OP_CLEAR, 8'h00,        11'd0,    1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}}
        };

        shadow_color = RESET_COLOR;
        blank_shadow();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // the block blanks its screen after reset before taking words
        wait_console_idle();

        send_idle_pct = 37;
        recv_idle_pct = 76;
        foreach (directed_rows[i])
            push_word(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].addr,
                      directed_rows[i].typed, directed_rows[i].want);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_console_idle();

            // backpressure profile per group of three segments
            case (seg / 3)
                0:       begin send_idle_pct = 37; recv_idle_pct = 76; end
                1:       begin send_idle_pct = 76; recv_idle_pct = 37; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase

            // black on black, then white on white, then random attributes
            if (seg == 0)
                color = 8'h00;
            else if (seg == 1)
                color = 8'hFF;
            else
                color = CHAR_W'($urandom_range(255));
            reg_write(COLOR_ADDR, PDATA_W'(color));
            shadow_color = color;
            reg_check(COLOR_ADDR, PDATA_W'(color));
            @(posedge clk);

            if ($urandom_range(3) == 0)
                push_word(OP_CLEAR, CHAR_W'($urandom_range(255)),
                          ADDR_W'($urandom_range(2047)), 1'b0, NO_WORD);

            target = DIRECTED_ROWS + (seg + 1) * SEG_WORDS;
            while (words_sent < target) begin
                pick = $urandom_range(99);
                if (pick < 38) begin
                    // text line: mostly short, sometimes long enough to wrap
                    run_len = ($urandom_range(4) == 0) ? $urandom_range(60, 100)
                                                       : $urandom_range(1, 20);
                    repeat (run_len) begin
                        pick = $urandom_range(99);
                        if (pick < 8)
                            ch = CHAR_TAB;
                        else if (pick < 11)
                            ch = CHAR_RETURN;
                        else
                            ch = CHAR_W'($urandom_range(255));
                        push_word(OP_PUT, ch, ADDR_W'($urandom_range(2047)), 1'b0, NO_WORD);
                    end
                    if ($urandom_range(9) < 7)
                        push_word(OP_PUT, CHAR_NEWLINE, ADDR_W'($urandom_range(2047)),
                                  1'b0, NO_WORD);
                end else if (pick < 66) begin
                    // newline burst pushes the cursor down to the scrolling rows
                    repeat ($urandom_range(1, 10))
                        push_word(OP_PUT, CHAR_NEWLINE, ADDR_W'($urandom_range(2047)),
                                  1'b0, NO_WORD);
                end else if (pick < 90) begin
                    repeat ($urandom_range(1, 3)) begin
                        pick = $urandom_range(9);
                        if (pick < 7)
                            addr = ADDR_W'($urandom_range(CELLS - 1));
                        else if (pick < 9)
                            addr = ADDR_W'(shadow_row * SCR_W + $urandom_range(SCR_W - 1));
                        else
                            addr = ADDR_W'($urandom_range(2047, CELLS));
                        push_word(OP_READ, CHAR_W'($urandom_range(255)), addr,
                                  1'b0, NO_WORD);
                    end
                end else if (pick < 92) begin
                    push_word(OP_CLEAR, CHAR_W'($urandom_range(255)),
                              ADDR_W'($urandom_range(2047)), 1'b0, NO_WORD);
                end else if (pick < 95) begin
                    push_word(OP_NONE, CHAR_W'($urandom_range(255)),
                              ADDR_W'($urandom_range(2047)), 1'b0, NO_WORD);
                end else begin
                    // raw noise word
                    push_word(op_t'($urandom_range(3)), CHAR_W'($urandom_range(255)),
                              ADDR_W'($urandom_range(2047)), 1'b0, NO_WORD);
                end
            end
        end

        wait_console_idle();
        // stray words after the last one still show up as faults here
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
